### hdl/ray_box_slab_test_macros.svh
// Assertion macros shared by the ray/box slab test RTL.
`ifndef RAY_BOX_SLAB_TEST_MACROS_SVH
`define RAY_BOX_SLAB_TEST_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RBST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define RBST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/rbst_pkg.sv
// Constants for the ray/box slab test block.
`default_nettype none
package rbst_pkg;
  localparam int RBST_COORD_WIDTH = 32;
  localparam int RBST_THR_WIDTH = 16;
  localparam logic [RBST_THR_WIDTH-1:0] RBST_THR_RESET = 16'd1;
  localparam int RBST_LATENCY = 3;
  localparam int RBST_AXES = 3;
endpackage
`default_nettype wire

### hdl/ray_box_slab_test.sv
// Ray versus axis-aligned box test, slab method, three-stage pipeline.
//
// Usage:
//   Pulse start with the box corners, ray origin and direction on the in_
//   ports. busy is always low, so a request is taken in every cycle that
//   start is high. out_valid is high for one cycle with out_hit, once the
//   request has passed through stages 1, 2 and 3, in request order.
//   Throughput: one request per clock.
//   Stage 1: slab numerators (p - o) signed by the direction, min/max,
//            parallel-axis decision and in-slab check.
//   Stage 2: cross products lo_j * d_i and hi_i * d_j, one
//            (W+1)x(W+1) multiplier per product; this sets the clock.
//   Stage 3: exact compares and the final AND.
//   The receiver cannot stall; results are shown for a single cycle.
//   cfg_we writes the parallel threshold (Q16.16 LSBs); write only while idle.
//   Reset (rst_n low, synchronous) clears the pipeline valids and sets the
//   threshold to 1. Data registers are not reset.
`default_nettype none
module ray_box_slab_test
  import rbst_pkg::*;
#(
  parameter int COORD_WIDTH = RBST_COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_box_min_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_box_min_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_box_min_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_box_max_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_box_max_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_box_max_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_origin_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_dir_z,
  output logic                               out_valid,
  output logic                               out_hit,
  input  wire logic                          cfg_we,
  input  wire logic [RBST_THR_WIDTH-1:0]     cfg_wdata
);
  `include "ray_box_slab_test_macros.svh"

  localparam int CW = COORD_WIDTH;
  localparam int PW = 2 * CW + 2;

  logic signed [CW-1:0] mn [RBST_AXES];
  logic signed [CW-1:0] mx [RBST_AXES];
  logic signed [CW-1:0] org [RBST_AXES];
  logic signed [CW-1:0] dir [RBST_AXES];

  assign mn[0] = in_box_min_x;  assign mn[1] = in_box_min_y;  assign mn[2] = in_box_min_z;
  assign mx[0] = in_box_max_x;  assign mx[1] = in_box_max_y;  assign mx[2] = in_box_max_z;
  assign org[0] = in_origin_x;  assign org[1] = in_origin_y;  assign org[2] = in_origin_z;
  assign dir[0] = in_dir_x;     assign dir[1] = in_dir_y;     assign dir[2] = in_dir_z;

  logic [RBST_THR_WIDTH-1:0] thr_r;

  // stage 1
  logic                  v1_r, miss1_r;
  logic [RBST_AXES-1:0]  slab1_r;
  logic signed [CW:0]    lo_r [RBST_AXES];
  logic signed [CW:0]    hi_r [RBST_AXES];
  logic [CW-1:0]         d_r [RBST_AXES];

  logic signed [CW:0]    lo_nxt [RBST_AXES];
  logic signed [CW:0]    hi_nxt [RBST_AXES];
  logic [CW-1:0]         d_nxt [RBST_AXES];
  logic [RBST_AXES-1:0]  slab_nxt;
  logic                  miss_nxt;

  always_comb begin
    logic signed [CW:0] n1, n2;
    logic               dneg;
    miss_nxt = 1'b0;
    for (int i = 0; i < RBST_AXES; i++) begin
      dneg = dir[i][CW-1];
      // negating the most negative code gives itself, which is its magnitude
      d_nxt[i] = dneg ? (~dir[i] + 1'b1) : dir[i];
      n1 = {mn[i][CW-1], mn[i]} - {org[i][CW-1], org[i]};
      n2 = {mx[i][CW-1], mx[i]} - {org[i][CW-1], org[i]};
      if (dneg) begin
        n1 = -n1;
        n2 = -n2;
      end
      lo_nxt[i] = (n1 <= n2) ? n1 : n2;
      hi_nxt[i] = (n1 <= n2) ? n2 : n1;
      slab_nxt[i] = !((d_nxt[i] == '0) || (d_nxt[i] < CW'(thr_r)));
      if (!slab_nxt[i] && ((org[i] < mn[i]) || (org[i] > mx[i])))
        miss_nxt = 1'b1;
    end
  end

  // stage 2
  logic                  v2_r, miss2_r;
  logic [RBST_AXES-1:0]  slab2_r, hineg2_r;
  logic signed [PW-1:0]  pl_r [RBST_AXES][RBST_AXES];
  logic signed [PW-1:0]  ph_r [RBST_AXES][RBST_AXES];

  // stage 3
  logic hit_nxt;
  always_comb begin
    hit_nxt = !miss2_r;
    for (int i = 0; i < RBST_AXES; i++) begin
      if (slab2_r[i]) begin
        if (hineg2_r[i]) hit_nxt = 1'b0;
        for (int j = 0; j < RBST_AXES; j++)
          if (slab2_r[j] && (pl_r[i][j] > ph_r[i][j])) hit_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= RBST_THR_RESET;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      v1_r      <= start;
      v2_r      <= v1_r;
      out_valid <= v2_r;
    end
    miss1_r <= miss_nxt;
    slab1_r <= slab_nxt;
    for (int i = 0; i < RBST_AXES; i++) begin
      lo_r[i] <= lo_nxt[i];
      hi_r[i] <= hi_nxt[i];
      d_r[i]  <= d_nxt[i];
    end
    miss2_r <= miss1_r;
    slab2_r <= slab1_r;
    for (int i = 0; i < RBST_AXES; i++) begin
      hineg2_r[i] <= hi_r[i][CW];
      // lo_j / d_j <= hi_i / d_i  <=>  lo_j * d_i <= hi_i * d_j
      for (int j = 0; j < RBST_AXES; j++) begin
        pl_r[i][j] <= lo_r[j] * $signed({1'b0, d_r[i]});
        ph_r[i][j] <= hi_r[i] * $signed({1'b0, d_r[j]});
      end
    end
    out_hit <= hit_nxt;
  end

  assign busy = 1'b0;

  `RBST_ASSERT(a_latency, out_valid |-> $past(start, RBST_LATENCY), "result without request")
  `RBST_ASSERT(a_miss, (v2_r && miss2_r) |=> (out_valid && !out_hit), "parallel miss lost")
  `RBST_ASSERT(a_inside, (v1_r && !miss1_r && (slab1_r == '0)) |-> ##2 (out_valid && out_hit),
               "all-parallel inside not a hit")
  `RBST_NEVER(a_busy, busy && start, "request refused")
endmodule
`default_nettype wire
